// ===== hw/rtl/sacf_pkg.sv =====
// Shared constants and types for the set-associative FIFO-replacement cache lookup.
`timescale 1ns / 1ps

package sacf_pkg;

	localparam int unsigned ADDR_W     = 32;
	localparam int unsigned SETS       = 16;
	localparam int unsigned WAYS       = 4;
	localparam int unsigned LINE_BYTES = 16;

	localparam int unsigned OFFSET_W = $clog2(LINE_BYTES);
	localparam int unsigned SET_W    = $clog2(SETS);
	localparam int unsigned WAY_W    = $clog2(WAYS);
	localparam int unsigned TAG_W    = 24;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [SET_W-1:0]  set_t;
	typedef logic [WAY_W-1:0]  way_t;
	typedef logic [TAG_W-1:0]  tag_t;
	typedef tag_t [WAYS-1:0]   tag_row_t;
	typedef logic [WAYS-1:0]   way_mask_t;

	typedef struct packed {
		logic hit;
		way_t way;
	} lookup_t;

endpackage

// ===== hw/rtl/sacf_way_select.sv =====
// Tag compare across all ways of a set and choice of hit or fill way.
`timescale 1ns / 1ps

module sacf_way_select (
	input  sacf_pkg::tag_row_t  row,
	input  sacf_pkg::way_mask_t valid,
	input  sacf_pkg::tag_t      tag,
	input  sacf_pkg::way_t      victim,
	output sacf_pkg::lookup_t   result
);
	import sacf_pkg::*;

	way_mask_t match;
	logic      hit_found;
	way_t      hit_way;
	logic      free_found;
	way_t      free_way;

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			match[w] = valid[w] && (row[w] == tag);
		end
	end

	// Lowest-numbered matching way, lowest-numbered invalid way.
	always_comb begin
		hit_found  = 1'b0;
		hit_way    = '0;
		free_found = 1'b0;
		free_way   = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (match[w]) begin
				hit_found = 1'b1;
				hit_way   = WAY_W'(w);
			end
			if (!valid[w]) begin
				free_found = 1'b1;
				free_way   = WAY_W'(w);
			end
		end
	end

	always_comb begin
		result.hit = hit_found;
		if (hit_found) begin
			result.way = hit_way;
		end else if (free_found) begin
			result.way = free_way;
		end else begin
			result.way = victim;
		end
	end

endmodule

// ===== hw/rtl/set_assoc_cache_fifo_lookup.sv =====
// Top level of the set-associative cache lookup with FIFO replacement.
`timescale 1ns / 1ps

// Cache tag lookup: each request carries a byte address; the line offset is
// dropped, the next bits pick one of SETS sets and the rest form the tag. The
// tag is compared against all WAYS ways of the set in parallel. A miss fills
// the first invalid way, or else the way named by the set's round-robin victim
// pointer (insertion order, hits do not refresh it), and the response reports
// the filled way. Throughput is one request per cycle while responses are taken;
// the tag RAM is read into stage 1 when a request is taken, then the compare
// result is written into the response register, held until taken. Tags live
// in a synchronous RAM with one row per set (one read and one write port);
// back-to-back requests to the same set are served by forwarding the row just
// written. Valid bits and victim pointers are flops cleared by reset, so no
// clearing pass is needed and the block takes requests right after reset. A
// stalled response holds the pipeline while at most one request waits behind it.

module set_assoc_cache_fifo_lookup (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  sacf_pkg::addr_t      address,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output logic                 hit,
	output sacf_pkg::set_t       set_index,
	output sacf_pkg::tag_t       tag_value,
	output sacf_pkg::way_t       way_index
);
	import sacf_pkg::*;

	// tag RAM, one row holds all ways of a set
	tag_row_t  tag_mem [SETS];

	way_mask_t valid_q  [SETS];
	way_t      victim_q [SETS];

	// stage 1: request waiting for its tag row
	logic      vld_s1;
	set_t      set_s1;
	tag_t      tag_s1;
	tag_row_t  rd_row_s1;
	logic      fwd_s1;
	tag_row_t  fwd_row_s1;

	// response register
	logic      rsp_valid_q;
	logic      hit_q;
	set_t      set_q;
	tag_t      tag_q;
	way_t      way_q;

	logic      req_fire;
	logic      s1_fire;
	logic      wr_en;
	set_t      req_set;
	tag_t      req_tag;
	tag_row_t  cur_row;
	tag_row_t  wr_row;
	lookup_t   lkp;

	assign req_set = address[OFFSET_W +: SET_W];
	assign req_tag = address[OFFSET_W + SET_W +: TAG_W];

	assign s1_fire   = vld_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !vld_s1 || s1_fire;
	assign req_fire  = req_valid && req_ready;

	// the row written at the edge this request read the RAM is newer than the read
	assign cur_row = fwd_s1 ? fwd_row_s1 : rd_row_s1;

	sacf_way_select u_way_select (
		.row    (cur_row),
		.valid  (valid_q[set_s1]),
		.tag    (tag_s1),
		.victim (victim_q[set_s1]),
		.result (lkp)
	);

	assign wr_en = s1_fire && !lkp.hit;

	always_comb begin
		wr_row          = cur_row;
		wr_row[lkp.way] = tag_s1;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tag_mem[set_s1] <= wr_row;
		end
		if (req_fire) begin
			rd_row_s1 <= tag_mem[req_set];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SETS; s++) begin
				valid_q[s]  <= '0;
				victim_q[s] <= '0;
			end
		end else if (wr_en) begin
			valid_q[set_s1][lkp.way] <= 1'b1;
			victim_q[set_s1]         <= (lkp.way == WAY_W'(WAYS - 1)) ? '0 : lkp.way + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req_fire) begin
			vld_s1 <= 1'b1;
		end else if (s1_fire) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			set_s1     <= req_set;
			tag_s1     <= req_tag;
			fwd_s1     <= wr_en && (set_s1 == req_set);
			fwd_row_s1 <= wr_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			hit_q <= lkp.hit;
			set_q <= set_s1;
			tag_q <= tag_s1;
			way_q <= lkp.way;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign hit       = hit_q;
	assign set_index = set_q;
	assign tag_value = tag_q;
	assign way_index = way_q;

endmodule

// ===== test/set_assoc_cache_fifo_lookup_tb.sv =====
// Self-checking testbench for the set-associative FIFO-replacement cache lookup.
`timescale 1ns / 1ps

// Every request the block takes goes through a shadow copy of the tag store, the
// valid bits and the per-set victim pointers, which yields the response that the
// block must give. Responses come back in order, so they are checked against a
// queue of predicted responses, field by field.
//
// Test sequence:
//   directed     - address extremes, hit after fill, fill of all four ways,
//                  FIFO eviction order, hit that must not move the victim
//                  pointer, re-fetch of an evicted line, back-to-back same set
//   random       - mostly addresses built from a small tag pool per set, so that
//                  hits, fills and evictions all occur; some fully random
//                  addresses; random idle bursts on both sides
//   backpressure - the response side holds off for a long stretch while
//                  requests keep coming, so the pipeline fills and stalls
//   streaming    - no idling at all, requests crowded onto two sets to work the
//                  forwarding of a row just written

module set_assoc_cache_fifo_lookup_tb;

	import sacf_pkg::*;

	localparam int CLK_PERIOD  = 8;
	localparam int RESET_LEN   = 11;
	localparam int MAX_REPORTS = 10;
	localparam int POOL_DEPTH  = 6;     // tags per set in the random pool, more than WAYS
	localparam int HOLD_LEN    = 200;   // long response hold-off, in cycles
	localparam int TAIL_CYCLES = 20;    // quiet time after the last response

	typedef struct packed {
		logic hit;
		set_t set_idx;
		tag_t tag;
		way_t way;
	} lookup_rsp_t;

	logic  clk;
	logic  arst_n;
	logic  req_valid;
	logic  req_ready;
	addr_t address;
	logic  rsp_valid;
	logic  rsp_ready;
	logic  hit;
	set_t  set_index;
	tag_t  tag_value;
	way_t  way_index;

	// Shadow of the cache state.
	tag_t shadow_tags  [SETS][WAYS];
	bit   shadow_valid [SETS][WAYS];
	way_t next_victim  [SETS];

	lookup_rsp_t pending_lookups[$];

	// Random tag pool, so that random traffic revisits lines.
	tag_t tag_pool [SETS][POOL_DEPTH];

	// Run controls shared between the stimulus and the response side.
	bit req_idle_on;
	bit rsp_idle_on;
	int hold_off_len;

	int sent_count;
	int rsp_count;
	int hit_count;
	int evict_count;
	int mismatches;

	set_assoc_cache_fifo_lookup dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.address   (address),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.hit       (hit),
		.set_index (set_index),
		.tag_value (tag_value),
		.way_index (way_index)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Generous limit: roughly 2000 requests with worst-case idling on both sides
	// and the long hold-off come to well under this.
	initial begin
		#5_000_000;
		$display("Timeout with %0d lookups still outstanding", pending_lookups.size());
		$display("== FAIL ==");
		$finish;
	end

	// Work out the response to one lookup and update the shadow state.
	// Hit: lowest matching valid way, state untouched. Miss: first invalid way,
	// else the victim pointer's way; the pointer then moves past the filled way.
	function automatic void predict_lookup(input addr_t a, output lookup_rsp_t r);
		set_t s;
		tag_t t;
		way_t w;
		bit   found;
		bit   have_free;

		s         = a[OFFSET_W +: SET_W];
		t         = tag_t'(a >> (OFFSET_W + SET_W));
		w         = '0;
		found     = 1'b0;
		have_free = 1'b0;
		for (int i = 0; i < WAYS; i++) begin
			if (!found && shadow_valid[s][i] && shadow_tags[s][i] == t) begin
				found = 1'b1;
				w     = way_t'(i);
			end
		end
		if (found) begin
			hit_count++;
		end else begin
			for (int i = 0; i < WAYS; i++) begin
				if (!have_free && !shadow_valid[s][i]) begin
					have_free = 1'b1;
					w         = way_t'(i);
				end
			end
			if (!have_free) begin
				w = next_victim[s];
				evict_count++;
			end
			shadow_tags[s][w]  = t;
			shadow_valid[s][w] = 1'b1;
			next_victim[s]     = way_t'((int'(w) + 1) % WAYS);
		end
		r.hit     = found;
		r.set_idx = s;
		r.tag     = t;
		r.way     = w;
	endfunction

	function automatic addr_t make_address(input tag_t t, input set_t s, input int off);
		return (addr_t'(t) << (OFFSET_W + SET_W)) | (addr_t'(s) << OFFSET_W) |
			addr_t'(off % LINE_BYTES);
	endfunction

	// Offer one request and hold it until taken; the prediction is made at the
	// accepting edge, in order with every other request.
	task automatic send_request(input addr_t a);
		lookup_rsp_t predicted;

		req_valid <= 1'b1;
		address   <= a;
		do @(posedge clk); while (!req_ready);
		predict_lookup(a, predicted);
		pending_lookups.push_back(predicted);
		sent_count++;
	endtask

	// Random request-side gap: drops valid for a random stretch while idling is on.
	task automatic maybe_idle();
		if (req_idle_on && $urandom_range(0, 7) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	// Stop offering and wait for every outstanding response.
	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending_lookups.size() != 0);
	endtask

	task automatic test_directed();
		addr_t seq[$];

		seq = '{
			32'h0000_0000,                            // cold miss, set 0, tag 0
			32'h0000_000F,                            // same line, top offset: hit
			32'hFFFF_FFFF,                            // all ones: set 15, top tag
			32'hFFFF_FFF0,                            // same line: hit
			make_address(24'h00_0001, 4'd5, 0),       // fill set 5 way by way
			make_address(24'h80_0000, 4'd5, 3),
			make_address(24'hAA_AAAA, 4'd5, 7),
			make_address(24'h55_5555, 4'd5, 15),
			make_address(24'h80_0000, 4'd5, 1),       // hit must not move the pointer
			make_address(24'h12_3456, 4'd5, 2),       // set full: oldest way goes
			make_address(24'h00_0001, 4'd5, 4),       // evicted line comes back: miss
			make_address(24'h80_0000, 4'd5, 5),
			make_address(24'h55_5555, 4'd5, 6),
			32'h0000_0000,
			make_address(24'h00_0000, 4'd5, 0),       // tag 0 in a set where it was never valid
			make_address(24'h55_5555, 4'd5, 9),
			32'h7FFF_FFFF,
			32'h8000_0000,
			32'hAAAA_AAAA,
			32'h5555_5555,
			32'hFFFF_FFFF
		};
		// back to back, to hit the same-set forwarding path
		req_idle_on = 1'b0;
		foreach (seq[i]) send_request(seq[i]);
		drain();
	endtask

	task automatic test_random_traffic(input int count);
		addr_t a;
		set_t  s;
		set_t  prev_set;
		int    pick;

		foreach (tag_pool[i, j]) tag_pool[i][j] = tag_t'($urandom);
		prev_set    = '0;
		req_idle_on = 1'b1;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				a = $urandom;
			end else begin
				s = (pick < 35) ? prev_set : set_t'($urandom_range(0, SETS - 1));
				if ($urandom_range(0, 31) == 0)
					tag_pool[s][$urandom_range(0, POOL_DEPTH - 1)] = tag_t'($urandom);
				a = make_address(tag_pool[s][$urandom_range(0, POOL_DEPTH - 1)], s,
					$urandom_range(0, LINE_BYTES - 1));
			end
			prev_set = a[OFFSET_W +: SET_W];
			send_request(a);
			maybe_idle();
		end
		drain();
	endtask

	// Response side stops for a long stretch; requests keep coming until the
	// block pushes back, then everything drains.
	task automatic test_backpressure(input int count);
		set_t s;

		req_idle_on  = 1'b0;
		hold_off_len = HOLD_LEN;
		for (int n = 0; n < count; n++) begin
			s = set_t'($urandom_range(0, SETS - 1));
			send_request(make_address(tag_pool[s][$urandom_range(0, POOL_DEPTH - 1)], s,
				$urandom_range(0, LINE_BYTES - 1)));
		end
		drain();
	endtask

	// Full rate, no idling anywhere, two sets only.
	task automatic test_streaming(input int count);
		set_t s;

		req_idle_on = 1'b0;
		rsp_idle_on = 1'b0;
		for (int n = 0; n < count; n++) begin
			s = set_t'($urandom_range(0, 1) ? 3 : 12);
			send_request(make_address(tag_pool[s][$urandom_range(0, POOL_DEPTH - 1)], s,
				$urandom_range(0, LINE_BYTES - 1)));
		end
		drain();
	endtask

	// Response side: random stall bursts, or one long hold-off on request.
	initial begin
		rsp_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_len != 0) begin
				rsp_ready <= 1'b0;
				for (int i = 0; i < hold_off_len; i++) @(posedge clk);
				hold_off_len = 0;
			end else if (rsp_idle_on && $urandom_range(0, 7) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				rsp_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Response checker: in-order compare against the predicted queue.
	always @(posedge clk) begin
		lookup_rsp_t want;
		lookup_rsp_t got;

		if (arst_n && rsp_valid && rsp_ready) begin
			got.hit     = hit;
			got.set_idx = set_index;
			got.tag     = tag_value;
			got.way     = way_index;
			rsp_count++;
			if (pending_lookups.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: response with nothing outstanding: hit=%0b set=%0d tag=%06h way=%0d",
						$realtime, got.hit, got.set_idx, got.tag, got.way);
			end else begin
				want = pending_lookups.pop_front();
				if (got.hit !== want.hit || got.set_idx !== want.set_idx ||
					got.tag !== want.tag || got.way !== want.way) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: lookup %0d mismatch: exp hit=%0b set=%0d tag=%06h way=%0d, got hit=%0b set=%0d tag=%06h way=%0d",
							$realtime, rsp_count, want.hit, want.set_idx, want.tag, want.way,
							got.hit, got.set_idx, got.tag, got.way);
				end
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		address      = '0;
		req_idle_on  = 1'b0;
		rsp_idle_on  = 1'b1;
		hold_off_len = 0;
		sent_count   = 0;
		rsp_count    = 0;
		hit_count    = 0;
		evict_count  = 0;
		mismatches   = 0;
		foreach (shadow_tags[i, j]) begin
			shadow_tags[i][j]  = '0;
			shadow_valid[i][j] = 1'b0;
		end
		foreach (next_victim[i]) next_victim[i] = '0;

		repeat (RESET_LEN) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_traffic(1550);
		test_backpressure(60);
		test_streaming(320);

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Lookups: %0d sent, %0d answered, %0d hits, %0d misses, %0d evictions",
			sent_count, rsp_count, hit_count, sent_count - hit_count, evict_count);
		$display("Covered fills, FIFO evictions, same-set streaming and a %0d-cycle stall; %0d mismatches",
			HOLD_LEN, mismatches);
		if (mismatches == 0 && pending_lookups.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
